// File: design/gfpd_pkg.sv
`timescale 1ns / 1ps
// gfpd_pkg: shared constants, types and helpers for the frequency-watt derating block.
// No dependencies.
package gfpd_pkg;

    localparam int QUALIFY_TICKS_DEF = 3;
    localparam int RAMP_STEPS_DEF    = 60000;
    localparam int HYSTERESIS_DEF    = 30;

    localparam int DERATE_DIV = 1000;
    localparam int RISE_DIV   = 6000;

    localparam int MUL_W  = 32;
    localparam int DVD_W  = 48;
    localparam int DVS_W  = 16;
    localparam int CFG_W  = 20;
    localparam int CIDX_W = 3;

    localparam logic [CIDX_W-1:0] REG_OVER_START   = 3'd0;
    localparam logic [CIDX_W-1:0] REG_OVER_RECOVER = 3'd1;
    localparam logic [CIDX_W-1:0] REG_OVER_DROP    = 3'd2;
    localparam logic [CIDX_W-1:0] REG_OVER_RISE    = 3'd3;
    localparam logic [CIDX_W-1:0] REG_OVER_HOLD    = 3'd4;
    localparam logic [CIDX_W-1:0] REG_UNDER_START  = 3'd5;
    localparam logic [CIDX_W-1:0] REG_UNDER_DROP   = 3'd6;

    localparam int F_ODEC  = 0;
    localparam int F_OBACK = 1;
    localparam int F_OFRZ  = 2;
    localparam int F_UDEC  = 3;
    localparam int F_UBACK = 4;
    localparam int F_UFRZ  = 5;

    localparam logic signed [31:0] FULL_Q30 = 32'sh4000_0000;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    function automatic logic [15:0] to_q15(input logic signed [33:0] v);
        logic [15:0] r;
        if (v <= 34'sd0) begin
            r = 16'd0;
        end else if (v >= 34'sh0_4000_0000) begin
            r = 16'h8000;
        end else begin
            r = v[30:15];
        end
        return r;
    endfunction

endpackage

// File: design/grid_frequency_power_derating.sv
`timescale 1ns / 1ps
// Frequency-watt power derating. A transaction runs through setup states (accept, prepare,
// dispatch); when a mode is derating, it then takes a bit-serial multiply, a bit-serial divide
// by 1000 and a second bit-serial multiply before the result is loaded; while a mode recovers,
// a single divide gives the ramp step; when no mode is active, the result is loaded directly.
// One transaction is worked at a time; the next is taken while the previous result waits in
// the output register.
// Depends on gfpd_pkg, gfpd_mul, gfpd_div.
module grid_frequency_power_derating #(
    parameter int QUALIFY_TICKS  = gfpd_pkg::QUALIFY_TICKS_DEF,
    parameter int RAMP_STEPS     = gfpd_pkg::RAMP_STEPS_DEF,
    parameter int HYSTERESIS_MHZ = gfpd_pkg::HYSTERESIS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [gfpd_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [gfpd_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [15:0]                   s_grid_freq,
    input  logic [15:0]                   s_ac_power,
    input  logic                          s_normal_state,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [15:0]                   m_power_limit
);
    import gfpd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_DISP = 3'd2;
    localparam logic [2:0] ST_MUL1 = 3'd3;
    localparam logic [2:0] ST_DIV1 = 3'd4;
    localparam logic [2:0] ST_MUL2 = 3'd5;
    localparam logic [2:0] ST_DIVR = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    localparam logic [2:0] P_NONE  = 3'd0;
    localparam logic [2:0] P_ODEC  = 3'd1;
    localparam logic [2:0] P_OBACK = 3'd2;
    localparam logic [2:0] P_UDEC  = 3'd3;
    localparam logic [2:0] P_UBACK = 3'd4;

    localparam logic [1:0]  QT   = 2'(QUALIFY_TICKS);
    localparam logic [15:0] RSTP = 16'(RAMP_STEPS);
    localparam logic [16:0] HYS  = 17'(HYSTERESIS_MHZ);

    // configuration
    logic [15:0] ostart_reg, orecov_reg, orise_reg, ohold_reg, ustart_reg;
    logic [19:0] odr_reg, udr_reg;

    // control state
    logic [2:0]  state_reg, state_next;
    logic [2:0]  path_reg, path_next;
    logic [1:0]  trip0_reg, trip0_next, trip1_reg, trip1_next;
    logic [1:0]  clr0_reg, clr0_next, clr1_reg, clr1_next;
    logic [5:0]  flags_reg, flags_next;
    logic signed [31:0] frozen_reg, frozen_next, fref_reg, fref_next;
    logic signed [31:0] prev_reg, prev_next, der_reg, der_next;
    logic [15:0] hold_reg, hold_next, ramp_reg, ramp_next;
    logic        m_valid_reg, m_valid_next;
    logic [15:0] limit_reg, limit_next;

    // transaction payload
    logic        op_reg, op_next, normal_reg, normal_next;
    logic [15:0] grid_reg, grid_next, ac_reg, ac_next;
    logic signed [31:0] base_reg, base_next;
    logic [31:0] abase_reg, abase_next;
    logic        neg_reg, neg_next;

    // serial units
    logic              mul_start, div_start;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [2*MUL_W-1:0] mul_p;
    logic [DVD_W-1:0]  div_dvd, div_q;
    logic [DVS_W-1:0]  div_dvs;
    unit_stat_t        mul_stat, div_stat;

    gfpd_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .p       (mul_p),
        .stat    (mul_stat)
    );

    gfpd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_q),
        .stat     (div_stat)
    );

    function automatic logic [1:0] qinc(input logic [1:0] c);
        return (c >= QT) ? QT : c + 2'd1;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sh7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -50'sh8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_power_limit = limit_reg;

    always_comb begin
        logic [1:0]         t;
        logic signed [31:0] acq, accl, fz, base, p, pf;
        logic signed [16:0] df;
        logic [15:0]        adf;
        logic [19:0]        ratio;
        logic signed [49:0] res, mm;
        logic signed [33:0] s34;
        logic [15:0]        hn;

        state_next   = state_reg;
        path_next    = path_reg;
        trip0_next   = trip0_reg;
        trip1_next   = trip1_reg;
        clr0_next    = clr0_reg;
        clr1_next    = clr1_reg;
        flags_next   = flags_reg;
        frozen_next  = frozen_reg;
        fref_next    = fref_reg;
        prev_next    = prev_reg;
        der_next     = der_reg;
        hold_next    = hold_reg;
        ramp_next    = ramp_reg;
        limit_next   = limit_reg;
        m_valid_next = m_valid_reg && !m_ready;
        op_next      = op_reg;
        normal_next  = normal_reg;
        grid_next    = grid_reg;
        ac_next      = ac_reg;
        base_next    = base_reg;
        abase_next   = abase_reg;
        neg_next     = neg_reg;
        mul_start    = 1'b0;
        div_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_dvd      = '0;
        div_dvs      = '0;

        acq   = $signed({1'b0, ac_reg, 15'd0});
        accl  = (acq > FULL_Q30) ? FULL_Q30 : acq;
        t     = '0;
        fz    = '0;
        base  = '0;
        df    = '0;
        adf   = '0;
        ratio = '0;
        mm    = $signed({2'b00, mul_p[63:16]});
        res   = neg_reg ? (50'(base_reg) + mm) : (50'(base_reg) - mm);
        p     = '0;
        pf    = '0;
        s34   = '0;
        hn    = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next     = s_opcode;
                    grid_next   = s_grid_freq;
                    ac_next     = s_ac_power;
                    normal_next = s_normal_state;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP: begin
                if (!op_reg) begin
                    if (grid_reg > ostart_reg) begin
                        clr0_next  = '0;
                        t          = qinc(trip0_reg);
                        trip0_next = t;
                        if (t >= QT) begin
                            flags_next[F_ODEC]  = 1'b1;
                            flags_next[F_OBACK] = 1'b1;
                            if (!flags_reg[F_OFRZ]) begin
                                frozen_next        = accl;
                                prev_next          = acq;
                                fref_next          = accl;
                                flags_next[F_OFRZ] = 1'b1;
                            end
                            hold_next = '0;
                        end
                    end else if (({1'b0, grid_reg} + HYS) < {1'b0, ostart_reg}) begin
                        trip0_next = '0;
                        t          = qinc(clr0_reg);
                        clr0_next  = t;
                        if (t >= QT) begin
                            flags_next[F_ODEC] = 1'b0;
                            flags_next[F_OFRZ] = 1'b0;
                        end
                    end
                end else begin
                    if (grid_reg < ustart_reg) begin
                        clr1_next  = '0;
                        t          = qinc(trip1_reg);
                        trip1_next = t;
                        if (t >= QT) begin
                            flags_next[F_UDEC]  = 1'b1;
                            flags_next[F_UBACK] = 1'b1;
                            flags_next[F_UFRZ]  = 1'b1;
                            ramp_next           = '0;
                            fz          = flags_reg[F_UFRZ] ? frozen_reg : acq;
                            frozen_next = (fz > FULL_Q30) ? FULL_Q30 : fz;
                        end
                    end else begin
                        trip1_next = '0;
                        t          = qinc(clr1_reg);
                        clr1_next  = t;
                        if (t >= QT) begin
                            flags_next[F_UDEC] = 1'b0;
                            flags_next[F_UFRZ] = 1'b0;
                        end
                    end
                end
                state_next = ST_DISP;
            end
            ST_DISP: begin
                if (!op_reg) begin
                    base  = (grid_reg > orecov_reg) ? fref_reg : frozen_reg;
                    df    = $signed({1'b0, grid_reg}) - $signed({1'b0, ostart_reg});
                    ratio = odr_reg;
                end else begin
                    base  = frozen_reg;
                    df    = $signed({1'b0, ustart_reg}) - $signed({1'b0, grid_reg});
                    ratio = udr_reg;
                end
                adf        = df[16] ? 16'(-df) : df[15:0];
                base_next  = base;
                abase_next = base[31] ? 32'(-base) : 32'(base);
                neg_next   = df[16] ^ base[31];
                if ((!op_reg && flags_reg[F_ODEC]) || (op_reg && flags_reg[F_UDEC])) begin
                    path_next  = op_reg ? P_UDEC : P_ODEC;
                    mul_start  = 1'b1;
                    mul_a      = {16'd0, adf};
                    mul_b      = {12'd0, ratio};
                    state_next = ST_MUL1;
                end else if (!op_reg && flags_reg[F_OBACK]) begin
                    path_next  = P_OBACK;
                    div_start  = 1'b1;
                    div_dvd    = {17'd0, orise_reg, 15'd0};
                    div_dvs    = 16'(RISE_DIV);
                    state_next = ST_DIVR;
                end else if (op_reg && flags_reg[F_UBACK]) begin
                    path_next  = P_UBACK;
                    div_start  = 1'b1;
                    div_dvd    = {2'd0, ramp_reg, 30'd0};
                    div_dvs    = RSTP;
                    state_next = ST_DIVR;
                end else begin
                    path_next  = P_NONE;
                    state_next = ST_FIN;
                end
            end
            ST_MUL1: begin
                if (mul_stat.done) begin
                    div_start  = 1'b1;
                    div_dvd    = mul_p[DVD_W-1:0];
                    div_dvs    = 16'(DERATE_DIV);
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1: begin
                if (div_stat.done) begin
                    mul_start  = 1'b1;
                    mul_a      = abase_reg;
                    mul_b      = div_q[MUL_W-1:0];
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2: begin
                if (mul_stat.done) begin
                    state_next = ST_FIN;
                end
            end
            ST_DIVR: begin
                if (div_stat.done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    case (path_reg)
                        P_ODEC: begin
                            p  = sat32(res);
                            pf = frozen_reg;
                            if (grid_reg > orecov_reg) begin
                                if (p > prev_reg) begin
                                    p = prev_reg;
                                end
                                prev_next   = p;
                                frozen_next = p;
                                pf          = p;
                            end
                            if (p > pf) begin
                                p = pf;
                            end else if (p < 32'sd0) begin
                                p = '0;
                            end
                            der_next   = p;
                            limit_next = to_q15(34'(p));
                        end
                        P_UDEC: begin
                            p = sat32(res);
                            if (p > FULL_Q30) begin
                                p = FULL_Q30;
                            end else if (p < 32'sd0) begin
                                p = '0;
                            end
                            der_next   = p;
                            limit_next = to_q15(34'(p));
                        end
                        P_OBACK: begin
                            p = der_reg;
                            if (grid_reg < orecov_reg) begin
                                hn = hold_reg + 16'd1;
                                if (hn >= ohold_reg) begin
                                    hold_next = ohold_reg;
                                    s34 = 34'(der_reg) + $signed({2'b00, div_q[31:0]});
                                    if (s34 > 34'(FULL_Q30)) begin
                                        p                   = FULL_Q30;
                                        flags_next[F_OBACK] = 1'b0;
                                    end else if (s34 < 34'sd0) begin
                                        p = '0;
                                    end else begin
                                        p = s34[31:0];
                                    end
                                    der_next = p;
                                end else begin
                                    hold_next = hn;
                                end
                            end
                            limit_next = to_q15(34'(p));
                        end
                        P_UBACK: begin
                            s34 = 34'(frozen_reg) + $signed({2'b00, div_q[31:0]});
                            hn  = normal_reg ? ramp_reg + 16'd1 : 16'd0;
                            if (hn >= RSTP) begin
                                ramp_next           = '0;
                                flags_next[F_UBACK] = 1'b0;
                            end else begin
                                ramp_next = hn;
                            end
                            if (s34 > 34'(FULL_Q30)) begin
                                s34 = 34'(FULL_Q30);
                            end
                            limit_next = to_q15(s34);
                        end
                        default: begin
                            limit_next = 16'h8000;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ostart_reg <= 16'd50200;
            orecov_reg <= 16'd50150;
            odr_reg    <= 20'd26214;
            orise_reg  <= 16'd3277;
            ohold_reg  <= 16'd100;
            ustart_reg <= 16'd47500;
            udr_reg    <= 20'd26214;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_OVER_START:   ostart_reg <= cfg_wr_data[15:0];
                REG_OVER_RECOVER: orecov_reg <= cfg_wr_data[15:0];
                REG_OVER_DROP:    odr_reg    <= cfg_wr_data;
                REG_OVER_RISE:    orise_reg  <= cfg_wr_data[15:0];
                REG_OVER_HOLD:    ohold_reg  <= cfg_wr_data[15:0];
                REG_UNDER_START:  ustart_reg <= cfg_wr_data[15:0];
                REG_UNDER_DROP:   udr_reg    <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            path_reg    <= P_NONE;
            trip0_reg   <= '0;
            trip1_reg   <= '0;
            clr0_reg    <= '0;
            clr1_reg    <= '0;
            flags_reg   <= '0;
            frozen_reg  <= '0;
            fref_reg    <= '0;
            prev_reg    <= '0;
            der_reg     <= '0;
            hold_reg    <= '0;
            ramp_reg    <= '0;
            m_valid_reg <= 1'b0;
            limit_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            path_reg    <= path_next;
            trip0_reg   <= trip0_next;
            trip1_reg   <= trip1_next;
            clr0_reg    <= clr0_next;
            clr1_reg    <= clr1_next;
            flags_reg   <= flags_next;
            frozen_reg  <= frozen_next;
            fref_reg    <= fref_next;
            prev_reg    <= prev_next;
            der_reg     <= der_next;
            hold_reg    <= hold_next;
            ramp_reg    <= ramp_next;
            m_valid_reg <= m_valid_next;
            limit_reg   <= limit_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        normal_reg <= normal_next;
        grid_reg   <= grid_next;
        ac_reg     <= ac_next;
        base_reg   <= base_next;
        abase_reg  <= abase_next;
        neg_reg    <= neg_next;
    end

    a_over_frz: assert property (@(posedge aclk) disable iff (!aresetn)
        flags_reg[F_ODEC] == flags_reg[F_OFRZ])
        else $error("over-frequency derate and freeze flags disagree");

    a_under_frz: assert property (@(posedge aclk) disable iff (!aresetn)
        flags_reg[F_UDEC] == flags_reg[F_UFRZ])
        else $error("under-frequency derate and freeze flags disagree");

    a_qual_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        trip0_reg <= QT && trip1_reg <= QT && clr0_reg <= QT && clr1_reg <= QT)
        else $error("qualifier count beyond limit");

    a_one_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_stat.busy && div_stat.busy))
        else $error("multiplier and divider busy together");

endmodule

// File: design/gfpd_mul.sv
`timescale 1ns / 1ps
// gfpd_mul: bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on gfpd_pkg.
module gfpd_mul (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [gfpd_pkg::MUL_W-1:0]          a,
    input  logic [gfpd_pkg::MUL_W-1:0]          b,
    output logic [2*gfpd_pkg::MUL_W-1:0]        p,
    output gfpd_pkg::unit_stat_t                stat
);
    import gfpd_pkg::*;

    localparam int CNT_W = $clog2(MUL_W);

    logic [MUL_W-1:0]   a_reg;
    logic [2*MUL_W-1:0] prod_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [MUL_W:0]     sum;

    assign sum = {1'b0, prod_reg[2*MUL_W-1:MUL_W]} + (prod_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg    <= a;
            prod_reg <= {{MUL_W{1'b0}}, b};
        end else if (busy_reg) begin
            prod_reg <= {sum, prod_reg[MUL_W-1:1]};
        end
    end

    assign p         = prod_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: design/gfpd_div.sv
`timescale 1ns / 1ps
// gfpd_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on gfpd_pkg.
module gfpd_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [gfpd_pkg::DVD_W-1:0]    dividend,
    input  logic [gfpd_pkg::DVS_W-1:0]    divisor,
    output logic [gfpd_pkg::DVD_W-1:0]    quotient,
    output gfpd_pkg::unit_stat_t          stat
);
    import gfpd_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: tb/tb_grid_frequency_power_derating.sv
`timescale 1ns / 1ps
// Testbench for grid_frequency_power_derating: random and directed derating ticks with a
// per-tick predictor of the over/under-frequency modes and an in-order result check.
// Depends on gfpd_pkg and the design sources.
module tb_grid_frequency_power_derating;
    import gfpd_pkg::*;

    localparam int QUAL = 3;
    localparam int RAMP_STEPS = 60000;
    localparam int HYST = 30;
    localparam longint FULL = 64'sd1 << 30;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam logic OP_OVER = 1'b0;
    localparam logic OP_UNDER = 1'b1;
    localparam logic [CIDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int FO_DEC = 0, FO_BACK = 1, FO_FRZ = 2, FU_DEC = 3, FU_BACK = 4, FU_FRZ = 5;

    class limit_board;
        longint unsigned o_start, o_recov, o_drop, o_rise, o_hold, u_start, u_drop;
        int unsigned trip[2], clr[2];
        bit [5:0] flags;
        longint frz, fref, prev, der;
        int unsigned hold, ramp;
        logic [15:0] pending[$];
        int errors;
        int seen;

        function void init();
            o_start = 50200; o_recov = 50150; o_drop = 26214; o_rise = 3277;
            o_hold = 100; u_start = 47500; u_drop = 26214;
            trip[0] = 0; trip[1] = 0; clr[0] = 0; clr[1] = 0; flags = 0;
            frz = 0; fref = 0; prev = 0; der = 0; hold = 0; ramp = 0;
            errors = 0; seen = 0;
        endfunction

        function void write_reg(logic [CIDX_W-1:0] idx, longint unsigned v);
            case (idx)
                REG_OVER_START: o_start = v & 16'hffff;
                REG_OVER_RECOVER: o_recov = v & 16'hffff;
                REG_OVER_DROP: o_drop = v & 20'hfffff;
                REG_OVER_RISE: o_rise = v & 16'hffff;
                REG_OVER_HOLD: o_hold = v & 16'hffff;
                REG_UNDER_START: u_start = v & 16'hffff;
                REG_UNDER_DROP: u_drop = v & 20'hfffff;
                default: ;
            endcase
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint scale_down(longint base, longint df, longint unsigned ratio);
            longint unsigned adf, ab, s;
            longint m;
            bit neg;
            adf = df < 0 ? -df : df;
            ab = base < 0 ? -base : base;
            s = adf * ratio / 1000;
            m = longint'((s * ab) >> 16);
            neg = (df < 0) != (base < 0);
            return clamp32(neg ? base + m : base - m);
        endfunction

        function logic [15:0] q15(longint v);
            if (v <= 0) return 16'd0;
            if (v >= FULL) return 16'h8000;
            return v[30:15];
        endfunction

        function int unsigned bump(int unsigned c);
            return c >= QUAL ? QUAL : c + 1;
        endfunction

        function logic [15:0] over_tick(longint g, longint ac);
            longint st, p;
            st = o_start;
            if (g > st) begin
                clr[0] = 0; trip[0] = bump(trip[0]);
                if (trip[0] >= QUAL) begin
                    flags[FO_DEC] = 1; flags[FO_BACK] = 1;
                    if (!flags[FO_FRZ]) begin
                        frz = ac > FULL ? FULL : ac;
                        prev = ac; flags[FO_FRZ] = 1; fref = frz;
                    end
                    hold = 0;
                end
            end else if (g < st - HYST) begin
                trip[0] = 0; clr[0] = bump(clr[0]);
                if (clr[0] >= QUAL) begin
                    flags[FO_DEC] = 0; flags[FO_FRZ] = 0;
                end
            end
            if (flags[FO_DEC]) begin
                if (g > longint'(o_recov)) begin
                    p = scale_down(fref, g - st, o_drop);
                    if (p > prev) p = prev;
                    prev = p; frz = p;
                end else p = scale_down(frz, g - st, o_drop);
                if (p > frz) p = frz;
                else if (p < 0) p = 0;
                der = p;
                return q15(p);
            end
            if (flags[FO_BACK]) begin
                if (g < longint'(o_recov)) begin
                    hold = (hold + 1) & 16'hffff;
                    if (hold >= o_hold) begin
                        hold = o_hold;
                        p = der + longint'((o_rise << 15) / 6000);
                        if (p > FULL) begin
                            p = FULL; flags[FO_BACK] = 0;
                        end else if (p < 0) p = 0;
                        der = p;
                    end
                end
                return q15(der);
            end
            return 16'h8000;
        endfunction

        function logic [15:0] under_tick(longint g, longint ac, bit nrm);
            longint st, p;
            st = u_start;
            if (g < st) begin
                clr[1] = 0; trip[1] = bump(trip[1]);
                if (trip[1] >= QUAL) begin
                    flags[FU_DEC] = 1; flags[FU_BACK] = 1; ramp = 0;
                    if (!flags[FU_FRZ]) begin
                        frz = ac; flags[FU_FRZ] = 1;
                    end
                    if (frz > FULL) frz = FULL;
                end
            end else begin
                trip[1] = 0; clr[1] = bump(clr[1]);
                if (clr[1] >= QUAL) begin
                    flags[FU_DEC] = 0; flags[FU_FRZ] = 0;
                end
            end
            if (flags[FU_DEC]) begin
                p = scale_down(frz, st - g, u_drop);
                if (p > FULL) p = FULL;
                else if (p < 0) p = 0;
                der = p;
                return q15(p);
            end
            if (flags[FU_BACK]) begin
                p = frz + longint'((longint'(ramp) << 30) / RAMP_STEPS);
                if (nrm) ramp = (ramp + 1) & 16'hffff;
                else ramp = 0;
                if (ramp >= RAMP_STEPS) begin
                    ramp = 0; flags[FU_BACK] = 0;
                end
                if (p > FULL) p = FULL;
                else if (p < 0) p = 0;
                return q15(p);
            end
            return 16'h8000;
        endfunction

        function void note_input(logic op, logic [15:0] g, logic [15:0] ac, logic nrm);
            longint acq;
            acq = longint'(ac) << 15;
            if (op == OP_UNDER) pending.push_back(under_tick(g, acq, nrm));
            else pending.push_back(over_tick(g, acq));
        endfunction

        function void check_result(logic [15:0] got);
            logic [15:0] exp_v;
            seen++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result power_limit=%0d", $time, got);
                errors++;
                return;
            end
            exp_v = pending.pop_front();
            if (got !== exp_v) begin
                $display("%0t: power_limit expected %0d actual %0d", $time, exp_v, got);
                errors++;
            end
        endfunction
    endclass

    logic aclk, aresetn;
    logic cfg_wr_en;
    logic [CIDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wr_data;
    logic s_valid, s_ready, s_opcode, s_normal_state;
    logic [15:0] s_grid_freq, s_ac_power;
    logic m_valid, m_ready;
    logic [15:0] m_power_limit;

    limit_board board;
    longint cycles;
    int stall_mode;
    int long_hold;
    int sent;

    grid_frequency_power_derating dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_grid_freq(s_grid_freq), .s_ac_power(s_ac_power),
        .s_normal_state(s_normal_state),
        .m_valid(m_valid), .m_ready(m_ready), .m_power_limit(m_power_limit)
    );

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        board = new();
        board.init();
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("grid_frequency_power_derating verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_power_limit);
        if (aresetn && s_valid && s_ready)
            board.note_input(s_opcode, s_grid_freq, s_ac_power, s_normal_state);
    end

    // receiver: no, random or pattern-based stalls by stall_mode, with a long hold-off while long_hold counts down
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (long_hold > 0) begin
            m_ready <= 1'b0;
            long_hold <= long_hold - 1;
        end else case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= cycles[2];
            default: m_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wr_data <= v;
        board.write_reg(idx, v);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_tick(logic op, logic [15:0] g, logic [15:0] ac, logic nrm);
        s_valid <= 1'b1; s_opcode <= op; s_grid_freq <= g;
        s_ac_power <= ac; s_normal_state <= nrm;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic idle_gap(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_freq(logic op);
        int r;
        longint c;
        r = $urandom_range(0, 9);
        c = (op == OP_OVER) ? board.o_start : board.u_start;
        if (r == 0) return $urandom;
        if (r == 1) return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        c = c + $signed($urandom_range(0, 400)) - 200;
        if (c < 0) c = 0;
        if (c > 65535) c = 65535;
        return c[15:0];
    endfunction

    function automatic logic [15:0] pick_power();
        case ($urandom_range(0, 5))
            0: return 16'hffff;
            1: return 16'h0000;
            2: return 16'h8000;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(int n);
        int burst, k;
        logic op;
        k = 0;
        while (k < n) begin
            burst = $urandom_range(1, 40);
            op = $urandom_range(0, 1);
            stall_mode = $urandom_range(0, 3);
            repeat (burst) begin
                if ($urandom_range(0, 7) == 0) op = ~op;
                send_tick(op, pick_freq(op), pick_power(), $urandom_range(0, 7) != 0);
                k++;
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 200));
        end
    endtask

    initial begin
        cycles = 0; stall_mode = 0; long_hold = 0; sent = 0;
        aresetn = 1'b0; cfg_wr_en = 1'b0; cfg_index = '0; cfg_wr_data = '0;
        s_valid = 1'b0; s_opcode = 1'b0; s_grid_freq = '0; s_ac_power = '0;
        s_normal_state = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle, over trip/derate/recover, under trip/recover, extremes
        send_tick(OP_OVER, 16'd50000, 16'd20000, 1'b1);
        repeat (4) send_tick(OP_OVER, 16'd50500, 16'd30000, 1'b1);
        send_tick(OP_OVER, 16'd50700, 16'd10000, 1'b1);
        send_tick(OP_OVER, 16'hffff, 16'hffff, 1'b1);
        repeat (3) send_tick(OP_OVER, 16'd50100, 16'd0, 1'b1);
        repeat (3) send_tick(OP_UNDER, 16'd47000, 16'hffff, 1'b1);
        send_tick(OP_UNDER, 16'd0, 16'h8000, 1'b0);
        repeat (3) send_tick(OP_UNDER, 16'd48000, 16'd0, 1'b1);
        send_tick(OP_UNDER, 16'd48000, 16'd0, 1'b0);
        repeat (3) send_tick(OP_OVER, 16'd0, 16'd100, 1'b0);
        drain();

        cfg_write(REG_OVER_HOLD, 20'd0);
        cfg_write(REG_OVER_RISE, 20'hffff);
        cfg_write(REG_OVER_START, 20'd10);
        cfg_write(REG_OVER_RECOVER, 20'd5);
        cfg_write(REG_OVER_DROP, 20'hfffff);
        cfg_write(REG_UNDER_START, 20'hffff);
        cfg_write(REG_UNDER_DROP, 20'hfffff);
        cfg_write(REG_UNMAPPED, 20'd123);
        run_phase(300);

        // long receiver hold-off with the sender still offering
        long_hold = 2000;
        run_phase(30);
        drain();

        cfg_write(REG_OVER_START, 20'd50200);
        cfg_write(REG_OVER_RECOVER, 20'd50150);
        cfg_write(REG_OVER_DROP, 20'd0);
        cfg_write(REG_OVER_RISE, 20'd0);
        cfg_write(REG_OVER_HOLD, 20'hffff);
        cfg_write(REG_UNDER_START, 20'd0);
        cfg_write(REG_UNDER_DROP, 20'd0);
        run_phase(300);
        drain();

        cfg_write(REG_OVER_START, 20'd50200);
        cfg_write(REG_OVER_RECOVER, 20'd50150);
        cfg_write(REG_OVER_DROP, 20'd26214);
        cfg_write(REG_OVER_RISE, 20'd60000);
        cfg_write(REG_OVER_HOLD, 20'd3);
        cfg_write(REG_UNDER_START, 20'd47500);
        cfg_write(REG_UNDER_DROP, 20'd26214);
        run_phase(650);
        drain();

        cfg_write(REG_OVER_DROP, $urandom_range(0, 20'hfffff));
        cfg_write(REG_UNDER_DROP, $urandom_range(0, 20'hfffff));
        cfg_write(REG_OVER_RISE, $urandom_range(0, 16'hffff));
        cfg_write(REG_OVER_HOLD, $urandom_range(0, 20));
        run_phase(650);
        drain();

        $display("Run sent %0d ticks over both modes under five register settings,", sent);
        $display("with %0d results checked and receiver hold-offs.", board.seen);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("grid_frequency_power_derating verification clean");
        else
            $display("grid_frequency_power_derating verification failed");
        $finish;
    end
endmodule
